// File: design/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PAD    = 5'b00010,
    S_ROUND  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  // input command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // byte position where the length field starts
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // compression functions
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // message schedule functions
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// File: design/sha256_stream_hasher.sv
// append transaction: the byte that completes a block keeps the block busy through
//   acceptance, 64 rounds on the shared round unit and the hash add
// finish transaction: padding bytes up to the end of the block, then the block; when fill is
//   56 or more, another padding block; then eight output transactions, held by out_stall
// input: no new byte is taken while a completed block is compressed
// reset: synchronous, loads the initial hash and clears counts; idle the next cycle
`default_nettype none

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        cmd,
  input  wire logic [7:0]  data_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] digest_word,
  output      logic [2:0]  word_index,
  output      logic        last_word
);

  sha256_pkg::state_t state;

  logic [31:0] hash [8];
  logic [31:0] work [8];
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic [5:0]  round_cnt;
  logic [2:0]  out_idx;
  logic        finishing;
  logic        pad_first;
  logic        len_ok;
  logic        pad_done;

  logic        in_acc;
  logic        out_acc;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic [7:0]  pad_byte;
  logic [63:0] len_sh;
  logic        load_work;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  // handshake
  assign in_stall  = (state != sha256_pkg::S_IDLE);
  assign out_valid = (state == sha256_pkg::S_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  // padding byte: marker, zeros, then big-endian bit length
  assign len_sh   = bit_length << {fill[2:0], 3'b000};
  assign pad_byte = pad_first ? sha256_pkg::PAD_MARK :
                    ((fill >= sha256_pkg::LEN_POS) && len_ok) ? len_sh[63:56] : 8'h00;

  assign shift_en   = (in_acc && (cmd == sha256_pkg::CMD_APPEND)) ||
                      (state == sha256_pkg::S_PAD);
  assign shift_byte = (state == sha256_pkg::S_PAD) ? pad_byte : data_byte;
  assign load_work  = shift_en && (fill == 6'd63);

  // shared round unit
  assign t1 = work[7] + sha256_pkg::big_sigma1(work[4]) +
              ((work[4] & work[5]) ^ (~work[4] & work[6])) +
              sha256_pkg::ROUND_K[round_cnt] + w[0];
  assign t2 = sha256_pkg::big_sigma0(work[0]) +
              ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
  assign w_new = sha256_pkg::small_sigma1(w[14]) + w[9] +
                 sha256_pkg::small_sigma0(w[1]) + w[0];

  // sequencer and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha256_pkg::S_IDLE;
      fill       <= '0;
      bit_length <= '0;
      round_cnt  <= '0;
      out_idx    <= '0;
      finishing  <= 1'b0;
      pad_first  <= 1'b0;
      len_ok     <= 1'b0;
      pad_done   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha256_pkg::INIT_H[i];
      end
    end else begin
      if (shift_en) begin
        fill <= fill + 6'd1;
      end
      if (load_work) begin
        round_cnt <= '0;
      end
      unique case (state)
        sha256_pkg::S_IDLE: begin
          if (in_acc) begin
            if (cmd == sha256_pkg::CMD_APPEND) begin
              bit_length <= bit_length + 64'd8;
              if (fill == 6'd63) begin
                state <= sha256_pkg::S_ROUND;
              end
            end else begin
              finishing <= 1'b1;
              pad_first <= 1'b1;
              pad_done  <= 1'b0;
              state     <= sha256_pkg::S_PAD;
            end
          end
        end
        sha256_pkg::S_PAD: begin
          pad_first <= 1'b0;
          if (pad_first) begin
            len_ok <= (fill < sha256_pkg::LEN_POS);
          end
          if (fill == 6'd63) begin
            pad_done <= len_ok && !pad_first;
            state    <= sha256_pkg::S_ROUND;
          end
        end
        sha256_pkg::S_ROUND: begin
          round_cnt <= round_cnt + 6'd1;
          if (round_cnt == 6'd63) begin
            state <= sha256_pkg::S_UPDATE;
          end
        end
        sha256_pkg::S_UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          if (!finishing) begin
            state <= sha256_pkg::S_IDLE;
          end else if (pad_done) begin
            out_idx <= '0;
            state   <= sha256_pkg::S_EMIT;
          end else begin
            // length goes into the second padding block
            len_ok <= 1'b1;
            state  <= sha256_pkg::S_PAD;
          end
        end
        sha256_pkg::S_EMIT: begin
          if (out_acc) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                hash[i] <= sha256_pkg::INIT_H[i];
              end
              bit_length <= '0;
              finishing  <= 1'b0;
              pad_done   <= 1'b0;
              state      <= sha256_pkg::S_IDLE;
            end
          end
        end
        default: begin
          state <= sha256_pkg::S_IDLE;
        end
      endcase
    end
  end

  // block buffer doubles as the rolling schedule; round variables
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= {w[i][23:0], w[i+1][31:24]};
      end
      w[15] <= {w[15][23:0], shift_byte};
    end else if (state == sha256_pkg::S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
    if (load_work) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= hash[i];
      end
    end else if (state == sha256_pkg::S_ROUND) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  // checks
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_acc && last_word |=> !out_valid && !in_stall)
    else $error("block not idle after last digest word");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (cmd == sha256_pkg::CMD_FINISH) |=> in_stall && !out_valid)
    else $error("finish transaction did not start padding");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == sha256_pkg::S_ROUND) && (round_cnt == 6'd63) |=>
    (state == sha256_pkg::S_UPDATE))
    else $error("round sequence did not end after 64 rounds");

  a_emit_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill == 6'd0))
    else $error("digest output with partial block held");

endmodule

`default_nettype wire

// File: bench/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps

// one digest word as it should leave the block
typedef struct packed {
  logic [31:0] word;
  logic [2:0]  slot;
  logic        last;
} digest_word_t;

// running sha-256 state of the message in flight and the digest words still owed
class digest_scoreboard;

  localparam bit [31:0] IV_WORDS [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam bit [31:0] ROUND_CONST [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam bit [7:0] PAD_BYTE = 8'h80;
  localparam int LEN_FIELD = 56;

  bit [31:0]    chain [8];
  bit [7:0]     blk [64];
  bit [5:0]     fill;
  bit [63:0]    msg_bits;
  digest_word_t owed_words [$];
  int           fails;

  function new();
    chain = IV_WORDS;
    fill = '0;
    msg_bits = '0;
    fails = 0;
  endfunction

  function bit [31:0] ror(bit [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of blk into chain
  function void compress_block();
    bit [31:0] w [16];
    bit [31:0] v [8];
    bit [31:0] wt, w15, w2, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    v = chain;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        w15 = w[(r - 15) & 15];
        w2 = w[(r - 2) & 15];
        s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
        s1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
        wt = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
        w[r & 15] = wt;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain[i] = chain[i] + v[i];
  endfunction

  // padding, length field, final block(s), then queue the eight words
  function void finish_message();
    int pos;
    pos = fill;
    blk[pos] = PAD_BYTE;
    pos++;
    if (pos > LEN_FIELD) begin
      for (int i = pos; i < 64; i++)
        blk[i] = '0;
      compress_block();
      pos = 0;
    end
    for (int i = pos; i < LEN_FIELD; i++)
      blk[i] = '0;
    for (int i = 0; i < 8; i++)
      blk[LEN_FIELD + i] = msg_bits[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++)
      owed_words.push_back('{word: chain[i], slot: 3'(i), last: (i == 7)});
    chain = IV_WORDS;
    fill = '0;
    msg_bits = '0;
  endfunction

  // accepted input transaction
  function void absorb(bit c, bit [7:0] b);
    if (c == sha256_pkg::CMD_APPEND) begin
      blk[fill] = b;
      msg_bits = msg_bits + 64'd8;
      fill = fill + 6'd1;
      if (fill == 6'd0)
        compress_block();
    end else begin
      finish_message();
    end
  endfunction

  // accepted output transaction against the oldest owed word
  function void check_digest_word(bit [31:0] word, bit [2:0] slot, bit last);
    digest_word_t want;
    if (owed_words.size() == 0) begin
      $display("%0t: digest word %h slot %0d last %0b arrived with none owed",
               $time, word, slot, last);
      fails++;
      return;
    end
    want = owed_words.pop_front();
    if (word !== want.word) begin
      $display("%0t: digest_word expected %h actual %h", $time, want.word, word);
      fails++;
    end
    if (slot !== want.slot) begin
      $display("%0t: word_index expected %0d actual %0d", $time, want.slot, slot);
      fails++;
    end
    if (last !== want.last) begin
      $display("%0t: last_word expected %0b actual %0b", $time, want.last, last);
      fails++;
    end
  endfunction

  function int pending();
    return owed_words.size();
  endfunction

endclass

module sha256_stream_hasher_tb;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = sha256_pkg::CMD_APPEND;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;

  digest_scoreboard board;

  sha256_stream_hasher i_dut (.*);

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic c, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    board.absorb(c, b);
  endtask

  // random bytes of the given length, closed by a finish
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_item(sha256_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
    send_item(sha256_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // output side: random stall, check each transaction taken
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall)
        board.check_digest_word(digest_word, word_index, last_word);
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // count cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("sha256_stream_hasher: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    int long_len [3][$];
    int phase_items;
    int len;
    board = new();
    long_len[0] = '{63};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, "abc", byte extremes, back-to-back finish
    src_idle_pct = 19;
    sink_stall_pct = 83;
    send_item(sha256_pkg::CMD_FINISH, 8'hFF);
    send_item(sha256_pkg::CMD_APPEND, 8'h61);
    send_item(sha256_pkg::CMD_APPEND, 8'h62);
    send_item(sha256_pkg::CMD_APPEND, 8'h63);
    send_item(sha256_pkg::CMD_FINISH, 8'h00);
    send_item(sha256_pkg::CMD_APPEND, 8'h00);
    send_item(sha256_pkg::CMD_APPEND, 8'hFF);
    send_item(sha256_pkg::CMD_APPEND, 8'h80);
    send_item(sha256_pkg::CMD_APPEND, 8'h01);
    send_item(sha256_pkg::CMD_FINISH, 8'h55);
    send_item(sha256_pkg::CMD_FINISH, 8'hAA);

    // random messages: in the first phase one that needs a second padding block, then short ones
    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 19 : (p == 1) ? 83 : 0;
      sink_stall_pct = (p == 0) ? 83 : (p == 1) ? 19 : 0;
      foreach (long_len[p][k])
        send_message(long_len[p][k]);
      phase_items = 0;
      while (phase_items < 6) begin
        len = $urandom_range(0, 12);
        send_message(len);
        phase_items += len + 1;
      end
    end
    in_valid <= 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.fails == 0 && board.pending() == 0)
      $display("sha256_stream_hasher: match");
    else
      $display("sha256_stream_hasher: mismatch");
    $finish;
  end

endmodule
